// ===== src/mpjs_pkg.sv =====
// Package with shared types and codes for the multi-policy job scheduler.
`default_nettype none
package mpjs_pkg;
	localparam int FUNC_W = 2;
	localparam int ID_W = 4;
	localparam int TIME_W = 32;
	localparam int PRI_IN_W = 8;
	localparam int SUM_W = 48;
	localparam int POL_W = 3;

	localparam logic [FUNC_W-1:0] FUNC_ARRIVE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_QUANTUM = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd2;

	localparam logic [POL_W-1:0] POL_FCFS = 3'd0;
	localparam logic [POL_W-1:0] POL_PRI = 3'd1;
	localparam logic [POL_W-1:0] POL_PPRI = 3'd2;
	localparam logic [POL_W-1:0] POL_SRTF = 3'd3;
	localparam logic [POL_W-1:0] POL_RR = 3'd4;
	localparam logic [POL_W-1:0] POL_SJF = 3'd5;

	// Candidate handed along the row of selection cells.
	typedef struct packed {
		logic found;
		logic [TIME_W-1:0] key;
		logic [TIME_W-1:0] arrival;
	} cand_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_OUT  = 3'b100
	} state_t;
endpackage
`default_nettype wire

// ===== src/mpjs_if.sv =====
// Valid/ready channel interface carrying one payload word.
`default_nettype none
interface mpjs_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/mpjs_cell.sv =====
// One job slot cell: holds the slot's state and compares it against the passing candidate.
`default_nettype none
module mpjs_cell
	import mpjs_pkg::*;
#(
	parameter int PRIORITY_BITS = 8
) (
	input wire clk,
	input wire arst_n,
	input wire [POL_W-1:0] policy,
	input wire wr_arrive,
	input wire wr_evict,
	input wire wr_dispatch,
	input wire wr_finish,
	input wire [TIME_W-1:0] event_time,
	input wire [TIME_W-1:0] run_length,
	input wire [PRIORITY_BITS-1:0] job_priority,
	input wire requeue,
	input wire scan_en,
	input wire cand_t cand_in,
	output cand_t cand_out,
	output logic beats,
	output logic valid,
	output logic started,
	output logic [TIME_W-1:0] arrival,
	output logic [TIME_W-1:0] length,
	output logic [TIME_W-1:0] first_start
);
	logic valid_q, queued_q, started_q;
	logic [TIME_W-1:0] arrival_q, length_q, exec_q, last_q, first_q;
	logic [PRIORITY_BITS-1:0] pri_q;
	logic [TIME_W-1:0] key, delta;
	logic [TIME_W:0] exec_sum;

	always_comb begin
		case (policy)
			POL_PRI, POL_PPRI: key = TIME_W'(pri_q);
			POL_SRTF: key = (length_q > exec_q) ? length_q - exec_q : '0;
			POL_RR: key = last_q;
			POL_SJF: key = length_q;
			default: key = arrival_q;
		endcase
		delta = event_time - last_q;
		exec_sum = {1'b0, exec_q} + {1'b0, delta};
		beats = scan_en && valid_q && queued_q && (!cand_in.found || key < cand_in.key
			|| (key == cand_in.key && arrival_q < cand_in.arrival));
		cand_out = beats ? cand_t'{found: 1'b1, key: key, arrival: arrival_q} : cand_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			queued_q <= 1'b0;
			started_q <= 1'b0;
		end else if (wr_arrive) begin
			valid_q <= 1'b1;
			queued_q <= 1'b1;
			started_q <= 1'b0;
		end else if (wr_finish) begin
			valid_q <= 1'b0;
			queued_q <= 1'b0;
			started_q <= 1'b0;
		end else if (wr_dispatch) begin
			queued_q <= 1'b0;
			started_q <= 1'b1;
		end else if (wr_evict && requeue) begin
			queued_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_arrive) begin
			arrival_q <= event_time;
			length_q <= run_length;
			pri_q <= job_priority;
			exec_q <= '0;
			last_q <= '0;
		end else begin
			if (wr_evict || wr_dispatch) last_q <= event_time;
			if (wr_evict && started_q) exec_q <= exec_sum[TIME_W] ? '1 : exec_sum[TIME_W-1:0];
			if (wr_dispatch && !started_q) first_q <= event_time;
		end
	end

	assign valid = valid_q;
	assign started = started_q;
	assign arrival = arrival_q;
	assign length = length_q;
	assign first_start = first_q;
endmodule
`default_nettype wire

// ===== src/multi_policy_job_scheduler.sv =====
// Top level of the multi-policy job scheduler: control, slot cell row and totals.
`default_nettype none
// Each event is held in a register after acceptance, applied, and then passed to the output
// state when it needs no selection; when a quantum expiry must pick the best queued job, a
// scan state lies between: the candidate walks the row of slot cells one cell per cycle, so
// the scan length sets the rate. The result word is held in an output register until taken;
// the next event is accepted only after that.
module multi_policy_job_scheduler
	import mpjs_pkg::*;
#(
	parameter int JOB_SLOTS = 16,
	parameter int PRIORITY_BITS = 8
) (
	input wire clk,
	input wire arst_n,
	input wire cfg_we,
	input wire [POL_W-1:0] cfg_wdata,
	mpjs_if.sink in_ch,
	mpjs_if.source out_ch
);
	localparam int SW = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
	localparam int CW = $clog2(JOB_SLOTS + 1);

	logic [POL_W-1:0] policy_q;
	state_t state_q;
	logic [FUNC_W-1:0] func_q;
	logic [ID_W-1:0] id_q;
	logic present_q;
	logic [TIME_W-1:0] time_q, len_q;
	logic [PRIORITY_BITS-1:0] pri_q;
	logic [CW-1:0] pos_q;
	cand_t cand_q;
	logic [SW-1:0] best_q;
	logic [TIME_W-1:0] jobs_q;
	logic [SUM_W-1:0] wait_q, turn_q, resp_q;
	logic out_valid_q, out_dv_q, out_status_q;
	logic [ID_W-1:0] out_job_q;

	logic id_ok, hit_valid, hit_started, preempt;
	logic [SW-1:0] id_slot;
	logic [TIME_W-1:0] hit_arr, hit_len, hit_first;
	logic [JOB_SLOTS-1:0] c_valid, c_started, c_beats;
	logic [TIME_W-1:0] c_arr [JOB_SLOTS];
	logic [TIME_W-1:0] c_len [JOB_SLOTS];
	logic [TIME_W-1:0] c_first [JOB_SLOTS];
	cand_t c_out [JOB_SLOTS];
	logic do_event, do_arrive, do_evict, do_finish, start_scan, disp_now;
	logic [SW-1:0] disp_slot;
	logic scan_done;
	logic [TIME_W-1:0] turn, resp;
	logic [TIME_W:0] waitd;

	assign id_ok = {{(32-ID_W){1'b0}}, id_q} < 32'(JOB_SLOTS);
	assign id_slot = SW'(id_q);
	assign hit_valid = id_ok && c_valid[id_slot];
	assign hit_started = c_started[id_slot];
	assign hit_arr = c_arr[id_slot];
	assign hit_len = c_len[id_slot];
	assign hit_first = c_first[id_slot];
	assign preempt = policy_q == POL_PPRI || policy_q == POL_SRTF || policy_q == POL_RR;

	// Event is applied in the cycle after acceptance (state IDLE with a held word).
	logic pend_q;
	assign do_event = pend_q;
	assign do_arrive = do_event && func_q == FUNC_ARRIVE && id_ok && !hit_valid;
	assign do_finish = do_event && func_q == FUNC_FINISH && hit_valid;
	assign do_evict = do_event && func_q == FUNC_QUANTUM && present_q && hit_valid;
	assign start_scan = do_event && func_q == FUNC_QUANTUM && (!present_q || hit_valid)
		&& !(present_q && !preempt);
	assign scan_done = state_q == ST_SCAN && pos_q == CW'(JOB_SLOTS);
	assign disp_now = (do_evict && !preempt) || (scan_done && cand_q.found);
	assign disp_slot = scan_done ? best_q : id_slot;

	assign turn = time_q - hit_arr;
	assign resp = hit_started ? hit_first - hit_arr : '0;
	assign waitd = {1'b0, turn} - {1'b0, hit_len};

	genvar g;
	generate
		for (g = 0; g < JOB_SLOTS; g++) begin : g_cell
			mpjs_cell #(.PRIORITY_BITS(PRIORITY_BITS)) u_cell (
				.clk(clk), .arst_n(arst_n), .policy(policy_q),
				.wr_arrive(do_arrive && id_slot == SW'(g)),
				.wr_evict(do_evict && id_slot == SW'(g)),
				.wr_dispatch(disp_now && disp_slot == SW'(g)),
				.wr_finish(do_finish && id_slot == SW'(g)),
				.event_time(time_q), .run_length(len_q), .job_priority(pri_q),
				.requeue(preempt),
				.scan_en(state_q == ST_SCAN && pos_q == CW'(g)),
				.cand_in(cand_q), .cand_out(c_out[g]), .beats(c_beats[g]),
				.valid(c_valid[g]), .started(c_started[g]), .arrival(c_arr[g]),
				.length(c_len[g]), .first_start(c_first[g])
			);
		end
	endgenerate

	assign in_ch.ready = state_q == ST_IDLE && !pend_q && !out_valid_q;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = {out_dv_q, out_job_q, out_status_q, jobs_q, wait_q, turn_q, resp_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FCFS;
			state_q <= ST_IDLE;
			pend_q <= 1'b0;
			pos_q <= '0;
			cand_q <= '0;
			best_q <= '0;
			jobs_q <= '0;
			wait_q <= '0;
			turn_q <= '0;
			resp_q <= '0;
			out_valid_q <= 1'b0;
			out_dv_q <= 1'b0;
			out_status_q <= 1'b0;
			out_job_q <= '0;
		end else begin
			if (cfg_we) policy_q <= cfg_wdata;
			if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						{func_q, id_q, present_q, time_q, len_q} <=
							in_ch.data[FUNC_W+ID_W+1+2*TIME_W+PRI_IN_W-1:PRI_IN_W];
						pri_q <= PRIORITY_BITS'(in_ch.data[PRI_IN_W-1:0]);
						pend_q <= 1'b1;
					end else if (pend_q) begin
						pend_q <= 1'b0;
						out_dv_q <= do_evict && !preempt;
						out_job_q <= (do_evict && !preempt) ? id_q : '0;
						out_status_q <= !(do_arrive || do_finish || start_scan || do_evict);
						if (do_arrive) jobs_q <= jobs_q + 1'b1;
						if (do_finish) begin
							turn_q <= turn_q + SUM_W'(turn);
							resp_q <= resp_q + SUM_W'(resp);
							wait_q <= wait_q + {{(SUM_W-TIME_W-1){waitd[TIME_W]}}, waitd};
						end
						if (start_scan) begin
							state_q <= ST_SCAN;
							pos_q <= '0;
							cand_q <= '0;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						out_dv_q <= cand_q.found;
						out_job_q <= cand_q.found ? ID_W'(best_q) : '0;
						state_q <= ST_OUT;
					end else begin
						cand_q <= c_out[pos_q[SW-1:0]];
						if (c_beats[pos_q[SW-1:0]]) best_q <= pos_q[SW-1:0];
						pos_q <= pos_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== tb/sv/schedule_checker.sv =====
// Scoreboard for the job scheduler: predicts each result word and compares it.
package sched_tb_pkg;
	import mpjs_pkg::*;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [ID_W-1:0] job_id;
		logic job_present;
		logic [TIME_W-1:0] event_time;
		logic [TIME_W-1:0] run_length;
		logic [PRI_IN_W-1:0] job_priority;
	} event_word_t;

	typedef struct packed {
		logic dispatch_valid;
		logic [ID_W-1:0] dispatch_job;
		logic status;
		logic [TIME_W-1:0] job_count;
		logic [SUM_W-1:0] wait_sum;
		logic [SUM_W-1:0] turnaround_sum;
		logic [SUM_W-1:0] response_sum;
	} result_word_t;

	localparam int NUM_SLOTS = 16;
	localparam logic [FUNC_W-1:0] FUNC_BAD = 2'd3;
	localparam logic [POL_W-1:0] POL_SPARE_LO = 3'd6;
	localparam logic [POL_W-1:0] POL_SPARE_HI = 3'd7;
endpackage

module schedule_checker
	import mpjs_pkg::*;
	import sched_tb_pkg::*;
(
	input wire clk,
	input wire arst_n,
	input wire cfg_we,
	input wire [POL_W-1:0] cfg_wdata,
	input wire in_valid,
	input wire in_ready,
	input event_word_t in_data,
	input wire out_valid,
	input wire out_ready,
	input result_word_t out_data,
	output int failures,
	output int outstanding
);
	logic [POL_W-1:0] policy;
	logic slot_used [NUM_SLOTS];
	logic queued [NUM_SLOTS];
	logic [TIME_W-1:0] arrived [NUM_SLOTS];
	logic [PRI_IN_W-1:0] prio [NUM_SLOTS];
	logic [TIME_W-1:0] length [NUM_SLOTS];
	logic [TIME_W-1:0] ran [NUM_SLOTS];
	logic [TIME_W-1:0] last_run [NUM_SLOTS];
	logic [TIME_W-1:0] started_at [NUM_SLOTS];
	logic started [NUM_SLOTS];
	logic [TIME_W-1:0] arrivals;
	logic [SUM_W-1:0] wait_acc, turn_acc, resp_acc;
	result_word_t expected_words [$];

	assign outstanding = expected_words.size();

	function automatic logic [TIME_W-1:0] rank_of(int s);
		case (policy)
			POL_PRI, POL_PPRI: rank_of = {24'd0, prio[s]};
			POL_SRTF: rank_of = (length[s] > ran[s]) ? length[s] - ran[s] : '0;
			POL_RR: rank_of = last_run[s];
			POL_SJF: rank_of = length[s];
			default: rank_of = arrived[s];
		endcase
	endfunction

	function automatic void start_job(int s, logic [TIME_W-1:0] t);
		queued[s] = 1'b0;
		last_run[s] = t;
		if (!started[s]) begin
			started_at[s] = t;
			started[s] = 1'b1;
		end
	endfunction

	function automatic result_word_t schedule_event(event_word_t e);
		result_word_t r;
		int id;
		logic done, found;
		int best;
		logic [TIME_W-1:0] bk, ba, k, d, x, turn;
		r = '0;
		id = e.job_id;
		if (e.func == FUNC_ARRIVE) begin
			if (slot_used[id]) begin
				r.status = 1'b1;
			end else begin
				slot_used[id] = 1'b1;
				queued[id] = 1'b1;
				arrived[id] = e.event_time;
				prio[id] = e.job_priority;
				length[id] = e.run_length;
				ran[id] = '0;
				last_run[id] = '0;
				started[id] = 1'b0;
				arrivals = arrivals + 1;
			end
		end else if (e.func == FUNC_QUANTUM) begin
			if (e.job_present && !slot_used[id]) begin
				r.status = 1'b1;
			end else begin
				done = 1'b0;
				if (e.job_present) begin
					if (started[id]) begin
						d = e.event_time - last_run[id];
						x = ran[id] + d;
						ran[id] = (x < d) ? '1 : x;
					end
					last_run[id] = e.event_time;
					if (!(policy == POL_PPRI || policy == POL_SRTF || policy == POL_RR)) begin
						start_job(id, e.event_time);
						r.dispatch_valid = 1'b1;
						r.dispatch_job = e.job_id;
						done = 1'b1;
					end else begin
						queued[id] = 1'b1;
					end
				end
				if (!done) begin
					found = 1'b0;
					best = 0;
					bk = '0;
					ba = '0;
					for (int s = 0; s < NUM_SLOTS; s++) begin
						if (slot_used[s] && queued[s]) begin
							k = rank_of(s);
							if (!found || k < bk || (k == bk && arrived[s] < ba)) begin
								found = 1'b1;
								best = s;
								bk = k;
								ba = arrived[s];
							end
						end
					end
					if (found) begin
						start_job(best, e.event_time);
						r.dispatch_valid = 1'b1;
						r.dispatch_job = best[ID_W-1:0];
					end
				end
			end
		end else if (e.func == FUNC_FINISH) begin
			if (!slot_used[id]) begin
				r.status = 1'b1;
			end else begin
				turn = e.event_time - arrived[id];
				turn_acc = turn_acc + {16'd0, turn};
				wait_acc = wait_acc + {16'd0, turn} - {16'd0, length[id]};
				if (started[id])
					resp_acc = resp_acc + {16'd0, started_at[id] - arrived[id]};
				slot_used[id] = 1'b0;
				queued[id] = 1'b0;
				started[id] = 1'b0;
			end
		end else begin
			r.status = 1'b1;
		end
		r.job_count = arrivals;
		r.wait_sum = wait_acc;
		r.turnaround_sum = turn_acc;
		r.response_sum = resp_acc;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_word_t want;
		if (!arst_n) begin
			policy = POL_FCFS;
			for (int s = 0; s < NUM_SLOTS; s++) begin
				slot_used[s] = 1'b0;
				queued[s] = 1'b0;
				started[s] = 1'b0;
			end
			arrivals = '0;
			wait_acc = '0;
			turn_acc = '0;
			resp_acc = '0;
			failures = 0;
			expected_words.delete();
		end else begin
			if (cfg_we)
				policy = cfg_wdata;
			if (in_valid && in_ready)
				expected_words.push_back(schedule_event(in_data));
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					failures = failures + 1;
					if (failures <= 10)
						$display("Unexpected result word %p", out_data);
				end else begin
					want = expected_words.pop_front();
					if (out_data !== want) begin
						failures = failures + 1;
						if (failures <= 10)
							$display("Mismatch: expected %p, got %p", want, out_data);
					end
				end
			end
		end
	end
endmodule

// ===== tb/sv/multi_policy_job_scheduler_tb.sv =====
// Testbench top: drives scheduler events under every policy and reports the verdict.
module multi_policy_job_scheduler_tb;
	import mpjs_pkg::*;
	import sched_tb_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [POL_W-1:0] cfg_wdata;
	int failures, outstanding;
	int cyc = 0;
	logic occupied [NUM_SLOTS];
	logic [TIME_W-1:0] now_ticks;

	mpjs_if #(.payload_t(event_word_t)) in_ch ();
	mpjs_if #(.payload_t(result_word_t)) out_ch ();

	multi_policy_job_scheduler uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	schedule_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.in_data(in_ch.data),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.out_data(out_ch.data),
		.failures(failures),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk)
		cyc <= cyc + 1;

	initial begin
		#10000000;
		$display("Some tests failed");
		$finish;
	end

	// The receiver counts its own cycles: one long hold-off, one long always-ready stretch.
	initial begin
		int rc;
		rc = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rc++;
			if (rc >= 3000 && rc < 3400)
				out_ch.ready <= 1'b0;
			else if (rc >= 5000 && rc < 7000)
				out_ch.ready <= 1'b1;
			else
				out_ch.ready <= ($urandom_range(0, 99) >= 32);
		end
	end

	task automatic send_word(input event_word_t w);
		while (!(cyc >= 5000 && cyc < 7000) && $urandom_range(0, 99) < 32) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= w;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		if (w.func == FUNC_ARRIVE)
			occupied[w.job_id] = 1'b1;
		else if (w.func == FUNC_FINISH)
			occupied[w.job_id] = 1'b0;
		@(negedge clk);
	endtask

	task automatic send_fields(input logic [FUNC_W-1:0] f, input int id, input logic p,
			input logic [TIME_W-1:0] t, input logic [TIME_W-1:0] len,
			input logic [PRI_IN_W-1:0] pri);
		event_word_t w;
		w.func = f;
		w.job_id = id[ID_W-1:0];
		w.job_present = p;
		w.event_time = t;
		w.run_length = len;
		w.job_priority = pri;
		send_word(w);
	endtask

	function automatic int pick_slot(logic want_used);
		int s;
		for (int tries = 0; tries < 8; tries++) begin
			s = $urandom_range(0, NUM_SLOTS - 1);
			if (occupied[s] == want_used)
				return s;
		end
		return $urandom_range(0, NUM_SLOTS - 1);
	endfunction

	task automatic send_random_event();
		event_word_t w;
		int r;
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 49) == 0)
			now_ticks = $urandom;
		else
			now_ticks = now_ticks + $urandom_range(0, 60);
		w = '0;
		w.event_time = now_ticks;
		w.run_length = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 200);
		w.job_priority = PRI_IN_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 3)
			: $urandom);
		w.job_present = 1'($urandom_range(0, 1));
		if (r < 40) begin
			w.func = FUNC_ARRIVE;
			w.job_id = ID_W'(pick_slot(1'b0));
		end else if (r < 75) begin
			w.func = FUNC_QUANTUM;
			w.job_id = ID_W'(pick_slot(1'b1));
		end else if (r < 93) begin
			w.func = FUNC_FINISH;
			w.job_id = ID_W'(pick_slot(1'b1));
		end else begin
			{w.func, w.job_id, w.job_present} = 7'($urandom);
			w.event_time = $urandom;
			w.run_length = $urandom;
		end
		send_word(w);
	endtask

	task automatic set_policy(input logic [POL_W-1:0] p);
		in_ch.valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (NUM_SLOTS + 6) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= p;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		logic [POL_W-1:0] plan [10];
		int guard;
		plan = '{POL_FCFS, POL_SRTF, POL_PRI, POL_RR, POL_PPRI, POL_SJF, POL_SPARE_HI,
			POL_SPARE_LO, POL_RR, POL_SRTF};
		now_ticks = '0;
		for (int s = 0; s < NUM_SLOTS; s++)
			occupied[s] = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_policy(POL_FCFS);
		send_fields(FUNC_QUANTUM, 0, 1'b0, 32'd0, 32'd0, 8'd0);
		send_fields(FUNC_ARRIVE, 0, 1'b0, 32'd0, 32'd0, 8'd0);
		send_fields(FUNC_ARRIVE, 15, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
		send_fields(FUNC_ARRIVE, 15, 1'b0, 32'd5, 32'd5, 8'd5);
		send_fields(FUNC_ARRIVE, 3, 1'b0, 32'd0, 32'd100, 8'd7);
		send_fields(FUNC_QUANTUM, 0, 1'b0, 32'd10, 32'd0, 8'd0);
		send_fields(FUNC_QUANTUM, 0, 1'b1, 32'd20, 32'd0, 8'd0);
		send_fields(FUNC_QUANTUM, 9, 1'b1, 32'd30, 32'd0, 8'd0);
		send_fields(FUNC_FINISH, 9, 1'b0, 32'd30, 32'd0, 8'd0);
		send_fields(FUNC_BAD, 3, 1'b1, 32'd31, 32'd1, 8'd1);
		send_fields(FUNC_FINISH, 0, 1'b0, 32'd40, 32'd0, 8'd0);
		send_fields(FUNC_FINISH, 15, 1'b0, 32'd2, 32'd0, 8'd0);
		set_policy(POL_RR);
		send_fields(FUNC_QUANTUM, 0, 1'b0, 32'd50, 32'd0, 8'd0);
		send_fields(FUNC_QUANTUM, 3, 1'b1, 32'hFFFF_FFF0, 32'd0, 8'd0);
		send_fields(FUNC_QUANTUM, 3, 1'b1, 32'hFFFF_FFE0, 32'd0, 8'd0);
		set_policy(POL_SRTF);
		send_fields(FUNC_ARRIVE, 4, 1'b0, 32'd60, 32'd200, 8'd1);
		send_fields(FUNC_QUANTUM, 3, 1'b1, 32'd70, 32'd0, 8'd0);
		send_fields(FUNC_FINISH, 3, 1'b0, 32'd80, 32'd0, 8'd0);
		send_fields(FUNC_FINISH, 4, 1'b0, 32'd90, 32'd0, 8'd0);

		foreach (plan[i]) begin
			set_policy(plan[i]);
			repeat (95) send_random_event();
		end

		in_ch.valid <= 1'b0;
		guard = 0;
		while (outstanding != 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		repeat (NUM_SLOTS + 20) @(negedge clk);
		if (failures == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
